@@ hdl/i2a_pkg.sv @@
// shared constants for the signed integer to decimal ascii unit
package i2a_pkg;

  localparam int CHAR_BITS = 6;
  localparam int BCD_BITS  = 4;

  localparam logic [CHAR_BITS-1:0] DIGIT_BASE = 6'd48;
  localparam logic [CHAR_BITS-1:0] MINUS_CHAR = 6'd45;

  localparam logic [BCD_BITS-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [BCD_BITS-1:0] BCD_ADJ     = 4'd3;

  typedef logic [CHAR_BITS-1:0] char_t;

  typedef struct packed {
    logic  valid;
    char_t character;
    logic  last;
  } char_beat_t;

endpackage

@@ hdl/signed_int_to_decimal_ascii_unit.sv @@
// top level: signed integer to decimal ascii character stream
//
//  channel  dir  beats per value  payload
//  s_axis   in   1                tdata: value
//  m_axis   out  1 to 11 (32b)    tdata: character, tlast: last
//
//  a value passes through the bit-serial bcd converter, then is loaded into the
//  serializer, which steps through the sign of a negative value and then every bcd
//  digit slot (10 at 32 bits), skipped leading zeros included, and returns to idle
//  before the next value is accepted; a stalled output holds the serializer.
//  s_axis_tready is high only while no conversion is in flight; the last
//  character may still wait in the output register when the next value comes.
//  rst is synchronous and clears all control state.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // value
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // character, zero pad
  output logic                              m_axis_tlast
);
  import i2a_pkg::*;

  localparam int DIGITS = ((VALUE_BITS - 1) * 31) / 100 + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  negative;
  logic                  in_beat;
  logic                  conv_done;
  logic [DIGITS*4-1:0]   bcd;
  logic                  emit_busy;
  char_beat_t            beat;

  assign raw     = s_axis_tdata[VALUE_BITS-1:0];
  assign mag     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (conv_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!emit_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      negative <= raw[VALUE_BITS-1];
    end
  end

  i2a_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_dabble (
    .clk  (clk),
    .rst  (rst),
    .load (in_beat),
    .mag  (mag),
    .done (conv_done),
    .bcd  (bcd)
  );

  i2a_emit #(
    .DIGITS (DIGITS)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (conv_done),
    .negative   (negative),
    .bcd        (bcd),
    .busy       (emit_busy),
    .beat       (beat),
    .beat_ready (m_axis_tready)
  );

  assign m_axis_tvalid = beat.valid;
  assign m_axis_tdata  = {2'b00, beat.character};
  assign m_axis_tlast  = beat.last;

endmodule

@@ hdl/i2a_dabble.sv @@
// bit-serial binary to bcd converter, shift and add three
module i2a_dabble #(
  parameter int VALUE_BITS = 32,
  parameter int DIGITS     = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  logic [VALUE_BITS-1:0]   mag,
  output logic                    done,
  output logic [DIGITS*4-1:0]     bcd
);
  import i2a_pkg::*;

  localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [VALUE_BITS-1:0] sh;
  logic [DIGITS*4-1:0]   bcd_adj;
  logic [CW-1:0]         cnt;
  logic                  busy;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= BCD_ADJ_MIN) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + BCD_ADJ;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !load && (cnt == CW'(VALUE_BITS - 1));
      if (load) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(VALUE_BITS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh  <= mag;
      bcd <= '0;
    end else if (busy) begin
      sh  <= {sh[VALUE_BITS-2:0], 1'b0};
      bcd <= {bcd_adj[DIGITS*4-2:0], sh[VALUE_BITS-1]};
    end
  end

endmodule

@@ hdl/i2a_emit.sv @@
// digit serializer: sign, leading zero skip, output register
module i2a_emit #(
  parameter int DIGITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  negative,
  input  logic [DIGITS*4-1:0]   bcd,
  output logic                  busy,
  output i2a_pkg::char_beat_t   beat,
  input  logic                  beat_ready
);
  import i2a_pkg::*;

  localparam int NW = $clog2(DIGITS + 1);

  logic [DIGITS*4-1:0] digs;
  logic [NW-1:0]       cnt;
  logic                sign_pend;
  logic                started;
  logic [3:0]          top_dig;
  logic                slot_free;
  logic                skip;
  logic                fire;

  assign top_dig   = digs[DIGITS*4-1 -: 4];
  assign slot_free = !beat.valid || beat_ready;
  assign skip      = !sign_pend && !started && top_dig == 4'd0 && cnt != NW'(1);
  assign fire      = busy && slot_free && (sign_pend || !skip);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      beat.valid     <= 1'b0;
      beat.character <= '0;
      beat.last      <= 1'b0;
      sign_pend      <= 1'b0;
      started        <= 1'b0;
      cnt            <= '0;
    end else begin
      if (fire) begin
        beat.valid     <= 1'b1;
        beat.character <= sign_pend ? MINUS_CHAR : DIGIT_BASE + {2'b00, top_dig};
        beat.last      <= !sign_pend && (cnt == NW'(1));
      end else if (beat_ready) begin
        beat.valid <= 1'b0;
      end
      if (load) begin
        busy      <= 1'b1;
        sign_pend <= negative;
        started   <= 1'b0;
        cnt       <= NW'(DIGITS);
      end else if (busy && slot_free) begin
        if (sign_pend) begin
          sign_pend <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
          if (!skip) begin
            started <= 1'b1;
            if (cnt == NW'(1)) begin
              busy <= 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digs <= bcd;
    end else if (busy && slot_free && !sign_pend) begin
      digs <= {digs[DIGITS*4-5:0], 4'd0};
    end
  end

endmodule

@@ tb/sv/signed_int_to_decimal_ascii_unit_check.sv @@
// checker for the integer to decimal ascii unit: predicts the character beats and compares them
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit_check #(
  parameter int VALUE_BITS = 32,
  parameter int IN_BITS    = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [IN_BITS-1:0] s_axis_tdata,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [7:0]         m_axis_tdata,
  input  logic               m_axis_tlast,
  output int                 fail_count,
  output int                 chars_pending,
  output int                 values_seen,
  output int                 chars_seen,
  output int                 negatives_seen,
  output int                 longest_text
);
  import i2a_pkg::*;

  typedef struct packed {
    char_t character;
    logic  last;
  } text_char_t;

  text_char_t pending_chars[$];

  function automatic void queue_decimal_text(input logic [VALUE_BITS-1:0] value);
    logic              negative;
    logic [VALUE_BITS:0] magnitude;
    char_t             digits[$];
    text_char_t        c;
    int                len;
    negative  = value[VALUE_BITS-1];
    magnitude = negative ? (~{1'b1, value} + 1'b1) : {1'b0, value};
    do begin
      digits.push_back(DIGIT_BASE + char_t'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    len = digits.size();
    if (negative) begin
      c.character = MINUS_CHAR;
      c.last      = 1'b0;
      pending_chars.push_back(c);
      negatives_seen++;
      len++;
    end
    for (int k = digits.size() - 1; k >= 0; k--) begin
      c.character = digits[k];
      c.last      = (k == 0);
      pending_chars.push_back(c);
    end
    if (len > longest_text) longest_text = len;
  endfunction

  initial begin
    fail_count     = 0;
    chars_pending  = 0;
    values_seen    = 0;
    chars_seen     = 0;
    negatives_seen = 0;
    longest_text   = 0;
  end

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        queue_decimal_text(s_axis_tdata[VALUE_BITS-1:0]);
        values_seen++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        chars_seen++;
        if (pending_chars.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected character beat tdata=%0d tlast=%0b",
                     $realtime, m_axis_tdata, m_axis_tlast);
        end else begin
          want = pending_chars.pop_front();
          if (m_axis_tdata !== {2'b00, want.character} ||
              m_axis_tlast !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: character beat %0d: expected tdata=%0d tlast=%0b,",
                        " got tdata=%0d tlast=%0b"},
                       $realtime, chars_seen, want.character, want.last,
                       m_axis_tdata, m_axis_tlast);
          end
        end
      end
      chars_pending = pending_chars.size();
    end
  end

endmodule

@@ tb/sv/signed_int_to_decimal_ascii_unit_test.sv @@
// testbench top for the integer to decimal ascii unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit_test;
  localparam int VALUE_BITS   = 32;
  localparam int IN_BITS      = ((VALUE_BITS + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 80;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [IN_BITS-1:0] s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [7:0]         m_axis_tdata;
  logic               m_axis_tlast;

  int fail_count, chars_pending, values_seen, chars_seen, negatives_seen, longest_text;

  logic gaps_on;
  logic hold_req;
  logic hold_started;
  int   hold_left;

  signed_int_to_decimal_ascii_unit #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  signed_int_to_decimal_ascii_unit_check #(.VALUE_BITS(VALUE_BITS)) check (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tlast   (m_axis_tlast),
    .fail_count     (fail_count),
    .chars_pending  (chars_pending),
    .values_seen    (values_seen),
    .chars_seen     (chars_seen),
    .negatives_seen (negatives_seen),
    .longest_text   (longest_text)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout with %0d characters still expected", chars_pending);
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_started  = 1'b0;
    hold_left     = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_started) begin
        hold_started = 1'b1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !gaps_on || ($urandom_range(99) >= 17);
      end
    end
  end

  task automatic send_value(input logic [VALUE_BITS-1:0] value);
    if (gaps_on && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_BITS'($urandom);
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_BITS'(value);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // mostly values of a random digit count, some raw bit patterns and the odd minimum
  function automatic logic [VALUE_BITS-1:0] pick_value();
    longint lo, hi, mag;
    int     ndig;
    case ($urandom_range(9))
      0, 1: return VALUE_BITS'($urandom);
      2:    return {1'b1, {(VALUE_BITS-1){1'b0}}};
      default: begin
        ndig = $urandom_range(1, 10);
        lo   = 1;
        for (int k = 1; k < ndig; k++) lo = lo * 10;
        hi   = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        mag  = lo + (longint'({$urandom, $urandom}) & 64'h3fff_ffff_ffff) % (hi - lo + 1);
        return $urandom_range(1) ? VALUE_BITS'(-mag) : VALUE_BITS'(mag);
      end
    endcase
  endfunction

  logic [VALUE_BITS-1:0] directed_values[$] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99, 32'd100,
    32'd999999999, 32'd1000000000, -32'sd1000000000, 32'd123456789, -32'sd123456789,
    32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'haaaa_aaaa,
    32'h0000_ffff, 32'hffff_0000, 32'd4000000, -32'sd4000000
  };

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    gaps_on       = 1'b0;
    hold_req      = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_values[i]) send_value(directed_values[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 0)   gaps_on  <= 1'b1;
      if (n == 120) hold_req <= 1'b1;
      if (n == 200) gaps_on  <= 1'b0;
      if (n == 280) gaps_on  <= 1'b1;
      send_value(pick_value());
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk);

    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d values (%0d negative) into %0d characters, longest text %0d",
             values_seen, negatives_seen, chars_seen, longest_text);
    $display("directed edge values, random digit counts, stalls on both sides, one long hold-off");
    if (fail_count == 0 && chars_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d characters never seen", fail_count, chars_pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
